@@ rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int ROWS    = 25;
  localparam int COLS    = 80;
  localparam int N_CELLS = ROWS * COLS;

  // Derived and fixed widths
  localparam int ADDR_W   = $clog2(N_CELLS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int COLX_W   = $clog2(COLS);
  localparam int COL_W    = $clog2(COLS + 1);
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  // Character and cell constants
  localparam logic [7:0]        NL_CHAR  = 8'h0A;
  localparam logic [CELL_W-1:0] CELL_OOR = 16'hFFFF;

  // Command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] row;
    logic [7:0] col;
  } req_word_t;

  typedef struct packed {
    logic [CELL_W-1:0]   cell_data;
    logic [CURSOR_W-1:0] cursor_pos;
    logic                out_of_range;
  } rsp_word_t;

  // Screen store port request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_RDWAIT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/tcw_screen_ram.sv @@
`default_nettype none

module tcw_screen_ram (
  input  wire logic                       clk,
  input  wire tcw_pkg::ram_req_t          req,
  output logic [tcw_pkg::CELL_W-1:0]      rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::N_CELLS];

  // Write one cell, read one cell into the output register
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcw_addr_unit.sv @@
`default_nettype none

module tcw_addr_unit (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [tcw_pkg::ROW_W-1:0]   row,
  input  wire logic [tcw_pkg::COLX_W-1:0]  col,
  output logic [tcw_pkg::ADDR_W-1:0]       addr
);

  // Form the linear cell address row*COLS+col and hold it
  always_ff @(posedge clk) begin
    if (load) begin
      addr <= tcw_pkg::ADDR_W'(row * tcw_pkg::COLS) + tcw_pkg::ADDR_W'(col);
    end
  end

endmodule

`default_nettype wire

@@ rtl/text_console_writer_top.sv @@
`default_nettype none

// Text console engine over a ROWS x COLS store of 16-bit cells (char 7:0,
// background 11:8, foreground 15:12). After reset the block clears all
// ROWS*COLS cells of the store, one cell per cycle, with req_stall high. Put
// char, write cell and an off-screen read cell then pass through an execute
// state; an on-screen read cell also waits in a read state for the
// registered store read. A put char that runs past the last row scrolls the
// screen first: one cell is copied per cycle through the single store port.
// One shared address unit forms row*COLS+col for every command. A finished
// result sits in the output register, so the next word is accepted while it
// waits.
module text_console_writer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire tcw_pkg::req_word_t req_word,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output tcw_pkg::rsp_word_t      rsp_word
);

  localparam int RSUM_W = tcw_pkg::ROW_W + 2;

  tcw_pkg::state_t state, state_next;

  // Cursor state
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tcw_pkg::COL_W-1:0]    cursor_col;
  logic [tcw_pkg::CURSOR_W-1:0] hw_cursor;

  // Captured word
  logic [1:0]                   cmd_q;
  logic [tcw_pkg::CELL_W-1:0]   cell_q;
  logic                         oor_q;
  logic                         nl_q;
  logic                         scroll_q;

  // Sweep counters
  logic [tcw_pkg::ADDR_W-1:0]   clr_cnt;
  logic [tcw_pkg::ADDR_W-1:0]   src;
  logic [tcw_pkg::ADDR_W-1:0]   cp_dst;
  logic                         cp_valid;

  logic                         accept;
  logic                         col_wrap;
  logic                         nl;
  logic [RSUM_W-1:0]            row_sum;
  logic                         need_scroll;
  logic [tcw_pkg::ROW_W-1:0]    put_row;
  logic [tcw_pkg::COLX_W-1:0]   put_col;
  logic                         in_oor;
  logic [tcw_pkg::ROW_W-1:0]    au_row;
  logic [tcw_pkg::COLX_W-1:0]   au_col;
  logic [tcw_pkg::ADDR_W-1:0]   addr;
  logic [tcw_pkg::CELL_W-1:0]   rdata;
  logic                         rsp_free;
  logic                         load_out;
  tcw_pkg::rsp_word_t           rsp_next;
  tcw_pkg::ram_req_t            ram_req;

  tcw_addr_unit u_addr (
    .clk  (clk),
    .load (accept),
    .row  (au_row),
    .col  (au_col),
    .addr (addr)
  );

  tcw_screen_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  assign accept   = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;

  // Work out where a put char lands
  always_comb begin
    col_wrap    = cursor_col >= tcw_pkg::COL_W'(tcw_pkg::COLS);
    nl          = req_word.ch == tcw_pkg::NL_CHAR;
    row_sum     = RSUM_W'(cursor_row) + RSUM_W'(col_wrap) + RSUM_W'(nl);
    need_scroll = row_sum >= RSUM_W'(tcw_pkg::ROWS);
    put_row     = need_scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                              : row_sum[tcw_pkg::ROW_W-1:0];
    put_col     = (col_wrap || nl) ? '0 : cursor_col[tcw_pkg::COLX_W-1:0];
    in_oor      = (req_word.row >= 8'(tcw_pkg::ROWS)) ||
                  (req_word.col >= 8'(tcw_pkg::COLS));
    if (req_word.cmd == tcw_pkg::CMD_PUT) begin
      au_row = put_row;
      au_col = put_col;
    end else begin
      au_row = req_word.row[tcw_pkg::ROW_W-1:0];
      au_col = req_word.col[tcw_pkg::COLX_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_CLEAR: begin
        if (clr_cnt == tcw_pkg::ADDR_W'(tcw_pkg::N_CELLS - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        if (scroll_q) begin
          state_next = tcw_pkg::ST_SCROLL;
        end else if (cmd_q == tcw_pkg::CMD_READ && !oor_q) begin
          state_next = tcw_pkg::ST_RDWAIT;
        end else if (rsp_free) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (src == tcw_pkg::ADDR_W'(tcw_pkg::N_CELLS - 1)) begin
          state_next = tcw_pkg::ST_SCROLL_END;
        end
      end
      tcw_pkg::ST_SCROLL_END: begin
        state_next = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_RDWAIT: begin
        if (rsp_free) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs: store port, result word
  always_comb begin
    req_stall = state != tcw_pkg::ST_IDLE;
    ram_req   = '0;
    load_out  = 1'b0;
    rsp_next  = '0;
    rsp_next.cursor_pos = hw_cursor;
    case (state)
      tcw_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt;
      end
      tcw_pkg::ST_EXEC: begin
        if (!scroll_q) begin
          case (cmd_q)
            tcw_pkg::CMD_PUT: begin
              if (!nl_q) begin
                ram_req.we          = 1'b1;
                ram_req.waddr       = addr;
                ram_req.wdata       = cell_q;
                rsp_next.cell_data  = cell_q;
                rsp_next.cursor_pos = tcw_pkg::CURSOR_W'(addr);
              end
              load_out = rsp_free;
            end
            tcw_pkg::CMD_WRITE: begin
              ram_req.we            = !oor_q;
              ram_req.waddr         = addr;
              ram_req.wdata         = cell_q;
              rsp_next.cell_data    = cell_q;
              rsp_next.out_of_range = oor_q;
              load_out              = rsp_free;
            end
            tcw_pkg::CMD_READ: begin
              ram_req.re            = !oor_q;
              ram_req.raddr         = addr;
              rsp_next.cell_data    = tcw_pkg::CELL_OOR;
              rsp_next.out_of_range = 1'b1;
              load_out              = oor_q && rsp_free;
            end
            default: begin
              load_out = rsp_free;
            end
          endcase
        end
      end
      tcw_pkg::ST_SCROLL: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = src;
      end
      tcw_pkg::ST_RDWAIT: begin
        rsp_next.cell_data = rdata;
        load_out           = rsp_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
    // Drain the copy pipeline: write the cell read in the cycle before
    if (cp_valid) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = cp_dst;
      ram_req.wdata = rdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      hw_cursor  <= '0;
      rsp_valid  <= 1'b0;
      cp_valid   <= 1'b0;
      scroll_q   <= 1'b0;
    end else begin
      state    <= state_next;
      cp_valid <= state == tcw_pkg::ST_SCROLL;
      if (state == tcw_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        scroll_q <= (req_word.cmd == tcw_pkg::CMD_PUT) && need_scroll;
        if (req_word.cmd == tcw_pkg::CMD_PUT) begin
          cursor_row <= put_row;
          cursor_col <= nl ? '0 : tcw_pkg::COL_W'(put_col) + 1'b1;
        end
      end else if (state == tcw_pkg::ST_SCROLL_END) begin
        scroll_q <= 1'b0;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
        if (cmd_q == tcw_pkg::CMD_PUT && !nl_q) begin
          hw_cursor <= tcw_pkg::CURSOR_W'(addr);
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req_word.cmd;
      cell_q <= {req_word.fg, req_word.bg, req_word.ch};
      oor_q  <= in_oor;
      nl_q   <= nl;
      src    <= tcw_pkg::ADDR_W'(tcw_pkg::COLS);
    end else if (state == tcw_pkg::ST_SCROLL) begin
      src <= src + 1'b1;
    end
    cp_dst <= src - tcw_pkg::ADDR_W'(tcw_pkg::COLS);
    if (load_out) begin
      rsp_word <= rsp_next;
    end
  end

  // Copy writes only trail scroll reads
  a_copy_in_scroll: assert property (@(posedge clk) disable iff (rst)
    cp_valid |-> (state == tcw_pkg::ST_SCROLL || state == tcw_pkg::ST_SCROLL_END))
    else $error("copy write outside scroll");

  // An accepted word always starts work
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == tcw_pkg::ST_EXEC)
    else $error("accepted word not executed");

  // Cursor stays on screen
  a_cursor_row: assert property (@(posedge clk) disable iff (rst)
    cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
    else $error("cursor row off screen");

  a_cursor_col: assert property (@(posedge clk) disable iff (rst)
    cursor_col <= tcw_pkg::COL_W'(tcw_pkg::COLS))
    else $error("cursor column past end");

  // Result only loads while no stalled word is held
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !load_out)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
